[hw/rtl/sfcc_pkg.sv]
// Shared types, constants and helper functions for the sensor frame checker.
`timescale 1ns / 1ps

package sfcc_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// byte positions within a six-byte frame
	localparam logic [2:0] POS_T_MSB = 3'd0;
	localparam logic [2:0] POS_T_LSB = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_MSB = 3'd3;
	localparam logic [2:0] POS_H_LSB = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	localparam int unsigned FULL_SCALE  = 65535;
	localparam int unsigned TEMP_SCALE  = 17500;
	localparam int unsigned TEMP_OFFSET = 4500;
	localparam int unsigned HUM_SCALE   = 10000;

	typedef struct packed {
		logic        status;
		logic [15:0] raw_t;
		logic [15:0] raw_h;
	} frame_t;

	// CRC-8, MSB first, one byte
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// floor(p / 65535) for p below 2^31: quotient estimate p >> 16 leaves a
	// remainder below twice the divisor, so one correction step suffices
	function automatic logic [15:0] div_full_scale(input logic [31:0] p);
		logic [15:0] q0;
		logic [16:0] r0;
		q0 = p[31:16];
		r0 = {1'b0, p[15:0]} + {1'b0, q0};
		return q0 + {15'd0, (r0 >= 17'(FULL_SCALE))};
	endfunction

endpackage

[hw/rtl/sfcc_frame.sv]
// Frame tracker: byte position, running CRC, raw word assembly and CRC status.
`timescale 1ns / 1ps

module sfcc_frame import sfcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	output logic       done,
	output frame_t     frame
);

	logic [2:0]  pos_q;
	logic [2:0]  pos;
	logic [7:0]  crc_q;
	logic [7:0]  crc_seed;
	logic [7:0]  crc_new;
	logic        crc_bad;
	logic        fail_q;
	logic [15:0] temp_word_q;
	logic [15:0] hum_word_q;

	always_comb begin
		pos      = (frame_start || pos_q > POS_H_CRC) ? POS_T_MSB : pos_q;
		crc_seed = (pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : crc_q;
		crc_new  = crc8_update(crc_seed, rx_byte);
		crc_bad  = (crc_q != rx_byte);
		done     = (pos == POS_H_CRC);
		frame.status = fail_q | crc_bad;
		frame.raw_t  = temp_word_q;
		frame.raw_h  = hum_word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_T_MSB;
			crc_q  <= CRC_INIT;
			fail_q <= 1'b0;
		end else if (en) begin
			case (pos)
				POS_T_MSB: begin
					fail_q <= 1'b0;
					crc_q  <= crc_new;
					pos_q  <= POS_T_LSB;
				end
				POS_T_LSB: begin
					crc_q <= crc_new;
					pos_q <= POS_T_CRC;
				end
				POS_T_CRC: begin
					if (crc_bad) begin
						fail_q <= 1'b1;
					end
					crc_q <= CRC_INIT;
					pos_q <= POS_H_MSB;
				end
				POS_H_MSB: begin
					crc_q <= crc_new;
					pos_q <= POS_H_LSB;
				end
				POS_H_LSB: begin
					crc_q <= crc_new;
					pos_q <= POS_H_CRC;
				end
				POS_H_CRC: begin
					if (crc_bad) begin
						fail_q <= 1'b1;
					end
					crc_q <= CRC_INIT;
					pos_q <= POS_T_MSB;
				end
				default: begin
					pos_q <= POS_T_MSB;
				end
			endcase
		end
	end

	// raw words, no reset needed: always written before a frame completes
	always_ff @(posedge clk) begin
		if (en) begin
			case (pos)
				POS_T_MSB: temp_word_q[15:8] <= rx_byte;
				POS_T_LSB: temp_word_q[7:0]  <= rx_byte;
				POS_H_MSB: hum_word_q[15:8]  <= rx_byte;
				POS_H_LSB: hum_word_q[7:0]   <= rx_byte;
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/sfcc_convert.sv]
// Raw word to engineering unit conversion (centi-degrees C and centi-percent RH).
`timescale 1ns / 1ps

module sfcc_convert import sfcc_pkg::*; (
	input  frame_t             frame,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi
);

	logic [30:0] temp_prod;
	logic [29:0] hum_prod;
	logic [15:0] temp_div;
	logic [15:0] hum_div;
	logic [15:0] temp_sum;

	always_comb begin
		temp_prod = 31'(frame.raw_t) * 31'(TEMP_SCALE);
		hum_prod  = 30'(frame.raw_h) * 30'(HUM_SCALE);
		temp_div  = div_full_scale({1'b0, temp_prod});
		hum_div   = div_full_scale({2'b00, hum_prod});
		temp_sum  = temp_div - 16'(TEMP_OFFSET);
		temperature_centi = signed'(temp_sum[14:0]);
		humidity_centi    = hum_div[13:0];
	end

endmodule

[hw/rtl/sensor_frame_crc_check_convert_top.sv]
// Top level of the sensor frame CRC checker and unit converter.
//
// Usage:
//   Input stream (s_*): one frame byte per item in s_tdata[7:0]; s_tuser set
//   marks the first byte of a frame and restarts the byte count. Bytes are
//   temperature MSB, LSB, CRC, then humidity MSB, LSB, CRC.
//   Output stream (m_*): one item per completed six-byte frame. m_tuser is
//   the CRC status (1 = mismatch in either word, data untrustworthy).
//   Throughput is one byte per cycle while the output register has room for a
//   frame's final byte; each byte is held in the input register, where CRC
//   update, word assembly and the constant-multiply conversion are done before
//   the output register. m_tvalid rises when the sixth byte moves from the
//   input register into the output register.
//   When m_tready is low with a result pending, the input register still
//   takes the non-final bytes of the next frame; the final byte waits there
//   and s_tready drops until the output register frees up.
//   Reset (arst_n low) empties both registers and restarts the frame count
//   at the temperature MSB with the CRC preset to 0xFF.
`timescale 1ns / 1ps

module sensor_frame_crc_check_convert_top import sfcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	// [14:0] temperature_centi, [28:15] humidity_centi, [44:29] raw_temperature,
	// [60:45] raw_humidity, [63:61] zero
	output logic [63:0] m_tdata,
	output logic        m_tuser    // [0] status
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;
	logic              advance;
	logic              out_free;
	logic              done;
	frame_t            frame;
	logic signed [14:0] temp_c;
	logic [13:0]       hum_c;

	logic              out_valid_q;
	logic              status_q;
	logic signed [14:0] temp_q;
	logic [13:0]       hum_q;
	logic [15:0]       raw_t_q;
	logic [15:0]       raw_h_q;

	sfcc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.done        (done),
		.frame       (frame)
	);

	sfcc_convert u_convert (
		.frame             (frame),
		.temperature_centi (temp_c),
		.humidity_centi    (hum_c)
	);

	assign out_free = !out_valid_q || m_tready;
	// only the frame-closing byte needs room in the output register
	assign advance  = valid_s1 && (!done || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && done) begin
			status_q <= frame.status;
			temp_q   <= temp_c;
			hum_q    <= hum_c;
			raw_t_q  <= frame.raw_t;
			raw_h_q  <= frame.raw_h;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, raw_h_q, raw_t_q, hum_q, temp_q};

	// converted values stay within the sensor's documented span
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[14:0]) >= -15'sd4500 &&
			$signed(m_tdata[14:0]) <= 15'sd13000 && m_tdata[28:15] <= 14'd10000))
		else $error("converted value out of range");

	// a full-scale raw temperature word hits the upper end point exactly (quotient correction step)
	a_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[44:29] == 16'hFFFF) |-> (m_tdata[14:0] == 15'd13000))
		else $error("temperature full-scale conversion wrong");

	// a byte held in the input register is not lost or overwritten
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(start_s1)))
		else $error("input register dropped a byte");

	// a result is only loaded when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> ($stable(raw_t_q) && $stable(status_q)))
		else $error("pending result overwritten");

endmodule

[bench/sensor_frame_crc_check_convert_top_tb.sv]
// Self-checking bench for the sensor frame CRC checker and unit converter.
`timescale 1ns / 1ps

module sensor_frame_crc_check_convert_top_tb;
	import sfcc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int TARGET_BYTES = 550;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		logic        status;
		logic [14:0] temp_centi;
		logic [13:0] hum_centi;
		logic [15:0] raw_t;
		logic [15:0] raw_h;
	} reading_t;

	// CRC-8 poly 0x31, one data bit at a time
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	class frame_scoreboard;
		logic [2:0]  pos;
		logic [7:0]  crc;
		logic [15:0] t_word;
		logic [15:0] h_word;
		logic        bad;
		reading_t    pending_readings[$];
		int          n_bytes;
		int          n_frames;
		int          n_flagged;
		int          n_errors;

		function new();
			pos = POS_T_MSB;
			crc = CRC_INIT;
			t_word = '0;
			h_word = '0;
			bad = 1'b0;
			n_bytes = 0;
			n_frames = 0;
			n_flagged = 0;
			n_errors = 0;
		endfunction

		function int pending();
			return pending_readings.size();
		endfunction

		// one accepted input item
		function void note_byte(logic [7:0] b, logic start);
			logic [2:0] p;
			reading_t r;
			longint t_val;
			longint h_val;
			n_bytes++;
			p = (start || pos > POS_H_CRC) ? POS_T_MSB : pos;
			pos = p + 3'd1;
			case (p)
				POS_T_MSB: begin
					bad = 1'b0;
					crc = crc8_step(CRC_INIT, b);
					t_word = {b, 8'h00};
				end
				POS_T_LSB: begin
					crc = crc8_step(crc, b);
					t_word[7:0] = b;
				end
				POS_T_CRC: begin
					if (crc != b) bad = 1'b1;
					crc = CRC_INIT;
				end
				POS_H_MSB: begin
					crc = crc8_step(CRC_INIT, b);
					h_word = {b, 8'h00};
				end
				POS_H_LSB: begin
					crc = crc8_step(crc, b);
					h_word[7:0] = b;
				end
				default: begin
					if (crc != b) bad = 1'b1;
					crc = CRC_INIT;
					t_val = -4500 + (longint'(17500) * t_word) / 65535;
					h_val = (longint'(10000) * h_word) / 65535;
					r.status = bad;
					r.temp_centi = t_val[14:0];
					r.hum_centi = h_val[13:0];
					r.raw_t = t_word;
					r.raw_h = h_word;
					pending_readings.push_back(r);
					pos = POS_T_MSB;
				end
			endcase
		endfunction

		// one accepted result item
		function void check_result(logic [63:0] data, logic st);
			reading_t r;
			if (pending_readings.size() == 0) begin
				$error("result with no frame outstanding: tdata %h status %b", data, st);
				n_errors++;
				return;
			end
			r = pending_readings.pop_front();
			n_frames++;
			if (r.status) n_flagged++;
			if (st !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, st);
				n_errors++;
			end
			if (data[14:0] !== r.temp_centi) begin
				$error("temperature_centi: expected %0d, got %0d",
					$signed(r.temp_centi), $signed(data[14:0]));
				n_errors++;
			end
			if (data[28:15] !== r.hum_centi) begin
				$error("humidity_centi: expected %0d, got %0d", r.hum_centi, data[28:15]);
				n_errors++;
			end
			if (data[44:29] !== r.raw_t) begin
				$error("raw_temperature: expected %h, got %h", r.raw_t, data[44:29]);
				n_errors++;
			end
			if (data[60:45] !== r.raw_h) begin
				$error("raw_humidity: expected %h, got %h", r.raw_h, data[60:45]);
				n_errors++;
			end
			if (data[63:61] !== 3'b000) begin
				$error("pad bits: expected 0, got %b", data[63:61]);
				n_errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;

	frame_scoreboard sb;
	bit calm;
	int cycle_count;

	sensor_frame_crc_check_convert_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		calm = 1'b0;
		cycle_count = 0;
		sb = new();
	end

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
	end

	task automatic send_byte(input logic [7:0] b, input logic start);
		while (!calm && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_byte(b, start);
	endtask

	// full frame; a corrupt word gets its CRC byte flipped by a nonzero mask
	task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
			input logic bad_t, input logic bad_h, input logic start);
		logic [7:0] t_crc;
		logic [7:0] h_crc;
		t_crc = crc8_step(crc8_step(CRC_INIT, t[15:8]), t[7:0]);
		h_crc = crc8_step(crc8_step(CRC_INIT, h[15:8]), h[7:0]);
		if (bad_t) t_crc ^= 8'($urandom_range(255, 1));
		if (bad_h) h_crc ^= 8'($urandom_range(255, 1));
		send_byte(t[15:8], start);
		send_byte(t[7:0], 1'b0);
		send_byte(t_crc, 1'b0);
		send_byte(h[15:8], 1'b0);
		send_byte(h[7:0], 1'b0);
		send_byte(h_crc, 1'b0);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) return 16'h0000;
		if (sel == 1) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	initial begin
		int r;
		int len;
		bit drained;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, a bad CRC in each word, resync on a partial frame
		send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
		send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b0);
		send_frame(16'h6666, 16'h8000, 1'b0, 1'b1, 1'b1);

		drained = 1'b0;
		while (sb.n_bytes < TARGET_BYTES) begin
			calm = (sb.n_bytes >= 150 && sb.n_bytes < 300);
			if (!drained && sb.n_bytes >= 320) begin
				wait_drained();
				drained = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 75) begin
				send_frame(pick_word(), pick_word(), $urandom_range(99) < 15,
					$urandom_range(99) < 15, 1'($urandom_range(1)));
			end else if (r < 90) begin
				// truncated frame, later bytes continue its count unless restarted
				len = $urandom_range(5, 1);
				send_byte(8'($urandom), 1'b1);
				for (int i = 1; i < len; i++) send_byte(8'($urandom), 1'b0);
			end else begin
				send_byte(8'($urandom), 1'($urandom_range(1)));
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes in frames, fragments and noise; checked %0d readings",
			sb.n_bytes, sb.n_frames);
		$display("%0d readings carried a CRC mismatch", sb.n_flagged);
		if (sb.n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[sensor_frame_crc_check_convert_top.f]
hw/rtl/sfcc_pkg.sv
hw/rtl/sfcc_frame.sv
hw/rtl/sfcc_convert.sv
hw/rtl/sensor_frame_crc_check_convert_top.sv
bench/sensor_frame_crc_check_convert_top_tb.sv
